@@ hdl/bpt_pkg.sv @@
// Package: constants, codes, state type and helpers of the batch perceptron trainer.
`default_nettype none
package bpt_pkg;

	localparam int MAX_ROWS      = 256;
	localparam int MAX_FEATURES  = 16;
	localparam int MAX_TARGETS   = 8;
	localparam int ROW_STRIDE    = MAX_FEATURES + MAX_TARGETS;
	localparam int SAMPLE_DEPTH  = MAX_ROWS * ROW_STRIDE;
	localparam int WEIGHT_DEPTH  = (MAX_FEATURES + 1) * MAX_TARGETS;
	localparam int SA_W          = 13;
	localparam int WA_W          = 8;
	localparam int F_W           = 5;
	localparam int K_W           = 3;
	localparam int R_W           = 8;

	localparam logic signed [15:0] BIAS_Q8   = -16'sd256;
	localparam logic signed [14:0] TENTH_Q16 = 15'sd6554;
	localparam logic [31:0]        LFSR_TAPS = 32'h8020_0003;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_TRAIN = 2'd1;
	localparam logic [1:0] FUNC_TEST  = 2'd2;

	localparam logic [2:0] REG_FEATURES = 3'd0;
	localparam logic [2:0] REG_TARGETS  = 3'd1;
	localparam logic [2:0] REG_ROWS     = 3'd2;
	localparam logic [2:0] REG_EPOCHCAP = 3'd3;
	localparam logic [2:0] REG_SEED     = 3'd4;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_PREDICT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_P_RD,
		S_P_MUL,
		S_P_ACC,
		S_T_RD,
		S_T_CALC,
		S_D_RD,
		S_D_MUL,
		S_D_WR,
		S_U_RD,
		S_U_CALC,
		S_U_WR,
		S_OUT
	} state_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] s);
		logic [31:0] n;
		n = s >> 1;
		if (s[0]) n = n ^ LFSR_TAPS;
		return n;
	endfunction

endpackage
`default_nettype wire

@@ hdl/batch_perceptron_trainer.sv @@
// Top level: batch perceptron trainer with sample, weight and delta memories.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tuser func, tdata row/column/value, tlast row_last
// m_*      out  m_tvalid/m_tready    tuser kind, tdata epochs/conv/target/pred, tlast last
// apb      in   psel/penable/pready  five 32-bit registers at 4*i
//
// A load beat is accepted while idle. Training draws every initial weight from the LFSR,
// then per epoch runs prediction, target and delta states per row and target, and updates
// all weights after an epoch with errors. A test beat with tlast predicts every target.
// Reset clears control state and marks every weight unwritten, so weights read as
// zero until training writes them; sample and delta memories hold their contents.
// A pending result in the output register stalls only the next result.
`default_nettype none
module batch_perceptron_trainer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // row_index[7:0], column_index[12:8], sample_value[28:13]
	input  wire  [1:0]  s_tuser,   // func
	input  wire         s_tlast,   // row_last
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // epochs_used[15:0], converged[16], target_number[19:17],
	                               // prediction[20]
	output logic        m_tuser,   // result_kind
	output logic        m_tlast,   // last_result
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bpt_pkg::state_t state_q, state_nx;

	logic [4:0]  fc_q;
	logic [3:0]  tc_q;
	logic [8:0]  rc_q;
	logic [15:0] cap_q;
	logic [31:0] seed_q;

	logic [bpt_pkg::F_W-1:0] fc_c;
	logic [bpt_pkg::K_W-1:0] tcm1;
	logic [bpt_pkg::R_W-1:0] rcm1;

	logic [15:0] sample_mem [bpt_pkg::SAMPLE_DEPTH];
	logic [31:0] weight_mem [bpt_pkg::WEIGHT_DEPTH];
	logic [39:0] delta_mem  [bpt_pkg::WEIGHT_DEPTH];
	logic [15:0] test_q     [bpt_pkg::MAX_FEATURES];

	logic [bpt_pkg::WEIGHT_DEPTH-1:0] wvalid_q;
	logic                             wvalid_rd_q;
	logic [31:0]                      weight_rd;

	logic [15:0] sample_rd_q;
	logic [31:0] weight_rd_q;
	logic [39:0] delta_rd_q;

	logic [bpt_pkg::F_W-1:0] f_q;
	logic [bpt_pkg::K_W-1:0] k_q;
	logic [bpt_pkg::R_W-1:0] r_q;
	logic [3:0]              n_q;
	logic [31:0]             lfsr_q;
	logic signed [53:0]      acc_q;
	logic signed [47:0]      prod_q;
	logic signed [16:0]      d_q;
	logic signed [32:0]      dprod_q;
	logic [39:0]             dold_q;
	logic signed [45:0]      inc_q;
	logic [31:0]             wold_q;
	logic                    err_q;
	logic                    conv_q;
	logic                    test_mode_q;
	logic [15:0]             epoch_q;

	logic        m_valid_q;
	logic [23:0] m_data_q;
	logic        m_kind_q;
	logic        m_last_q;

	logic        s_acc;
	logic [1:0]  func;
	logic [7:0]  row_in;
	logic [4:0]  col_in;
	logic [15:0] val_in;
	logic        cfg_wr;

	logic [bpt_pkg::SA_W-1:0] row_base, load_addr, sample_raddr;
	logic [bpt_pkg::WA_W-1:0] wd_addr;
	logic                     sample_we, weight_we, delta_we;
	logic [31:0]              weight_wd;
	logic [39:0]              delta_wd;
	logic                     out_load;
	logic                     k_end, f_end, r_end;

	logic [31:0]        lfsr_nx;
	logic signed [29:0] winit_prod;
	logic [31:0]        winit;
	logic signed [15:0] x_train, x_test;
	logic signed [46:0] wsum;
	logic [31:0]        wsat;
	logic signed [53:0] dscaled;

	assign func   = s_tuser;
	assign row_in = s_tdata[7:0];
	assign col_in = s_tdata[12:8];
	assign val_in = s_tdata[28:13];
	assign s_acc  = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	assign fc_c = (fc_q == 5'd0) ? 5'd1 :
		(fc_q > 5'(bpt_pkg::MAX_FEATURES)) ? 5'(bpt_pkg::MAX_FEATURES) : fc_q;
	assign tcm1 = (tc_q == 4'd0) ? 3'd0 :
		(tc_q > 4'(bpt_pkg::MAX_TARGETS)) ? 3'(bpt_pkg::MAX_TARGETS - 1) : 3'(tc_q - 4'd1);
	assign rcm1 = (rc_q == 9'd0) ? 8'd0 :
		(rc_q > 9'(bpt_pkg::MAX_ROWS)) ? 8'(bpt_pkg::MAX_ROWS - 1) : 8'(rc_q - 9'd1);

	assign k_end = (k_q == tcm1);
	assign f_end = (f_q == fc_c);
	assign r_end = (r_q == rcm1);

	assign row_base  = (13'(r_q) << 4) + (13'(r_q) << 3);
	assign load_addr = (13'(row_in) << 4) + (13'(row_in) << 3) + 13'(col_in);
	assign sample_raddr = (state_q == bpt_pkg::S_T_RD) ?
		row_base + 13'(fc_c) + 13'(k_q) : row_base + 13'(f_q);
	assign wd_addr = {f_q, k_q};

	assign weight_rd = wvalid_rd_q ? weight_rd_q : 32'd0;

	assign lfsr_nx    = bpt_pkg::lfsr_next(lfsr_q);
	assign winit_prod = 30'(signed'(lfsr_nx[15:0])) * 30'(bpt_pkg::TENTH_Q16);
	assign winit      = 32'(winit_prod >>> 15);

	assign x_train = f_end ? bpt_pkg::BIAS_Q8 : signed'(sample_rd_q);
	assign x_test  = f_end ? bpt_pkg::BIAS_Q8 : signed'(test_q[f_q[3:0]]);

	assign dscaled = 54'(signed'(delta_rd_q)) * 54'(bpt_pkg::TENTH_Q16) + 54'sd128;
	assign wsum    = 47'(signed'(wold_q)) + 47'(inc_q);
	assign wsat    = (wsum > 47'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
		(wsum < -47'sh8000_0000) ? 32'h8000_0000 : wsum[31:0];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= 5'd2;
			tc_q   <= 4'd1;
			rc_q   <= 9'd4;
			cap_q  <= 16'd10000;
			seed_q <= 32'd1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				bpt_pkg::REG_FEATURES: fc_q   <= pwdata[4:0];
				bpt_pkg::REG_TARGETS:  tc_q   <= pwdata[3:0];
				bpt_pkg::REG_ROWS:     rc_q   <= pwdata[8:0];
				bpt_pkg::REG_EPOCHCAP: cap_q  <= pwdata[15:0];
				bpt_pkg::REG_SEED:     seed_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			bpt_pkg::REG_FEATURES: prdata = {27'd0, fc_q};
			bpt_pkg::REG_TARGETS:  prdata = {28'd0, tc_q};
			bpt_pkg::REG_ROWS:     prdata = {23'd0, rc_q};
			bpt_pkg::REG_EPOCHCAP: prdata = {16'd0, cap_q};
			bpt_pkg::REG_SEED:     prdata = seed_q;
			default:               prdata = 32'd0;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (sample_we) sample_mem[load_addr] <= val_in;
		sample_rd_q <= sample_mem[sample_raddr];
	end

	always_ff @(posedge clk) begin
		if (weight_we) weight_mem[wd_addr] <= weight_wd;
		weight_rd_q <= weight_mem[wd_addr];
		wvalid_rd_q <= wvalid_q[wd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wvalid_q <= '0;
		else if (weight_we) wvalid_q[wd_addr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (delta_we) delta_mem[wd_addr] <= delta_wd;
		delta_rd_q <= delta_mem[wd_addr];
	end

	always_ff @(posedge clk) begin
		if (s_acc && func == bpt_pkg::FUNC_TEST && col_in < 5'(bpt_pkg::MAX_FEATURES))
			test_q[col_in[3:0]] <= val_in;
	end

	// outputs and write strobes
	always_comb begin
		s_tready  = (state_q == bpt_pkg::S_IDLE);
		out_load  = (state_q == bpt_pkg::S_OUT) && (!m_valid_q || m_tready);
		sample_we = s_acc && func == bpt_pkg::FUNC_LOAD &&
			col_in < 5'(bpt_pkg::ROW_STRIDE);
		weight_we = 1'b0;
		weight_wd = wsat;
		delta_we  = 1'b0;
		delta_wd  = 40'd0;
		case (state_q)
			bpt_pkg::S_INIT: begin
				weight_we = (n_q == 4'd15);
				weight_wd = winit;
				delta_we  = (n_q == 4'd15);
			end
			bpt_pkg::S_D_WR: begin
				delta_we = 1'b1;
				delta_wd = dold_q + 40'(dprod_q);
			end
			bpt_pkg::S_U_WR: begin
				weight_we = 1'b1;
				delta_we  = 1'b1;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bpt_pkg::S_IDLE: begin
				if (s_acc && func == bpt_pkg::FUNC_TRAIN) state_nx = bpt_pkg::S_INIT;
				else if (s_acc && func == bpt_pkg::FUNC_TEST && s_tlast)
					state_nx = bpt_pkg::S_P_RD;
			end
			bpt_pkg::S_INIT:
				if (n_q == 4'd15 && k_end && f_end) state_nx = bpt_pkg::S_P_RD;
			bpt_pkg::S_P_RD:  state_nx = bpt_pkg::S_P_MUL;
			bpt_pkg::S_P_MUL: state_nx = bpt_pkg::S_P_ACC;
			bpt_pkg::S_P_ACC: begin
				if (!f_end) state_nx = bpt_pkg::S_P_RD;
				else if (test_mode_q) state_nx = bpt_pkg::S_OUT;
				else state_nx = bpt_pkg::S_T_RD;
			end
			bpt_pkg::S_T_RD:   state_nx = bpt_pkg::S_T_CALC;
			bpt_pkg::S_T_CALC: state_nx = bpt_pkg::S_D_RD;
			bpt_pkg::S_D_RD:   state_nx = bpt_pkg::S_D_MUL;
			bpt_pkg::S_D_MUL:  state_nx = bpt_pkg::S_D_WR;
			bpt_pkg::S_D_WR: begin
				if (!f_end || !k_end || !r_end) state_nx = f_end ? bpt_pkg::S_P_RD :
					bpt_pkg::S_D_RD;
				else if (err_q) state_nx = bpt_pkg::S_U_RD;
				else state_nx = bpt_pkg::S_OUT;
			end
			bpt_pkg::S_U_RD:   state_nx = bpt_pkg::S_U_CALC;
			bpt_pkg::S_U_CALC: state_nx = bpt_pkg::S_U_WR;
			bpt_pkg::S_U_WR: begin
				if (!(k_end && f_end)) state_nx = bpt_pkg::S_U_RD;
				else if (epoch_q < cap_q) state_nx = bpt_pkg::S_P_RD;
				else state_nx = bpt_pkg::S_OUT;
			end
			bpt_pkg::S_OUT: begin
				if (out_load) begin
					if (test_mode_q && !k_end) state_nx = bpt_pkg::S_P_RD;
					else state_nx = bpt_pkg::S_IDLE;
				end
			end
			default: state_nx = bpt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bpt_pkg::S_IDLE;
		else state_q <= state_nx;
	end

	// loop counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q         <= '0;
			k_q         <= '0;
			r_q         <= '0;
			n_q         <= '0;
			lfsr_q      <= 32'd1;
			err_q       <= 1'b0;
			conv_q      <= 1'b0;
			test_mode_q <= 1'b0;
			epoch_q     <= '0;
		end else begin
			case (state_q)
				bpt_pkg::S_IDLE: begin
					f_q <= '0;
					k_q <= '0;
					r_q <= '0;
					n_q <= '0;
					if (s_acc && func == bpt_pkg::FUNC_TRAIN) begin
						lfsr_q      <= (seed_q == 32'd0) ? 32'd1 : seed_q;
						test_mode_q <= 1'b0;
						epoch_q     <= '0;
						err_q       <= 1'b0;
					end else if (s_acc && func == bpt_pkg::FUNC_TEST && s_tlast) begin
						test_mode_q <= 1'b1;
					end
				end
				bpt_pkg::S_INIT: begin
					lfsr_q <= lfsr_nx;
					n_q    <= n_q + 4'd1;
					if (n_q == 4'd15) begin
						if (k_end) begin
							k_q <= '0;
							f_q <= f_end ? '0 : f_q + 5'd1;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				bpt_pkg::S_P_ACC: if (!f_end) f_q <= f_q + 5'd1; else if (!test_mode_q) f_q <= '0;
				bpt_pkg::S_T_CALC: if (d_q != 17'sd0 || 1'b0) err_q <= err_q;
				bpt_pkg::S_D_MUL: if (d_q != 17'sd0) err_q <= 1'b1;
				bpt_pkg::S_D_WR: begin
					if (!f_end) begin
						f_q <= f_q + 5'd1;
					end else begin
						f_q <= '0;
						if (!k_end) begin
							k_q <= k_q + 3'd1;
						end else begin
							k_q <= '0;
							if (!r_end) r_q <= r_q + 8'd1;
							else begin
								r_q    <= '0;
								conv_q <= !err_q;
							end
						end
					end
				end
				bpt_pkg::S_U_WR: begin
					if (k_end) begin
						k_q <= '0;
						f_q <= f_end ? '0 : f_q + 5'd1;
						if (f_end) begin
							err_q <= 1'b0;
							if (epoch_q < cap_q) epoch_q <= epoch_q + 16'd1;
							else conv_q <= 1'b0;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				bpt_pkg::S_OUT: begin
					if (out_load && test_mode_q && !k_end) begin
						k_q <= k_q + 3'd1;
						f_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			bpt_pkg::S_P_MUL:
				prod_q <= 48'(test_mode_q ? x_test : x_train) * 48'(signed'(weight_rd));
			bpt_pkg::S_P_ACC:
				acc_q <= ((f_q == '0) ? 54'sd0 : acc_q) + 54'(prod_q);
			bpt_pkg::S_T_CALC:
				d_q <= 17'(signed'(sample_rd_q)) - (acc_q[53] ? 17'sd0 : 17'sd1);
			bpt_pkg::S_D_MUL: begin
				dprod_q <= 33'(x_train) * 33'(d_q);
				dold_q  <= delta_rd_q;
			end
			bpt_pkg::S_U_CALC: begin
				inc_q  <= 46'(dscaled >>> 8);
				wold_q <= weight_rd;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (out_load) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (test_mode_q) begin
				m_kind_q <= bpt_pkg::KIND_PREDICT;
				m_data_q <= {3'd0, !acc_q[53], k_q, 1'b0, 16'd0};
				m_last_q <= k_end;
			end else begin
				m_kind_q <= bpt_pkg::KIND_REPORT;
				m_data_q <= {3'd0, 1'b0, 3'd0, conv_q, epoch_q};
				m_last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("result register overwritten");
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == bpt_pkg::KIND_REPORT) |-> m_tlast)
		else $error("training report without last");
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(weight_we || delta_we) |-> (wd_addr < 8'(bpt_pkg::WEIGHT_DEPTH)))
		else $error("weight address out of range");

endmodule
`default_nettype wire

@@ sim/bpt_checker.sv @@
// Checker for the batch perceptron trainer: tracks config and beats, predicts results, compares.
`timescale 1ns / 1ps
module bpt_checker
	import bpt_pkg::*;
(
	input  logic        clk,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	typedef struct {
		logic        kind;
		logic [15:0] epochs;
		logic        conv;
		logic [2:0]  tnum;
		logic        pred;
		logic        last;
	} result_t;

	result_t     result_q[$];
	logic [15:0] samples [0:SAMPLE_DEPTH-1];
	int          weights [0:WEIGHT_DEPTH-1];
	longint      deltas  [0:WEIGHT_DEPTH-1];
	logic [15:0] test_vec [0:MAX_FEATURES-1];
	logic [4:0]  cfg_features = 5'd2;
	logic [3:0]  cfg_targets  = 4'd1;
	logic [8:0]  cfg_rows     = 9'd4;
	logic [15:0] cfg_cap      = 16'd10000;
	logic [31:0] cfg_seed     = 32'd1;
	logic [31:0] lfsr;

	initial begin
		fails = 0;
		pending = 0;
		foreach (samples[i]) samples[i] = '0;
		foreach (weights[i]) weights[i] = 0;
		foreach (deltas[i]) deltas[i] = 0;
		foreach (test_vec[i]) test_vec[i] = '0;
	end

	function automatic int clampi(input int v, input int lo, input int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic fire(input longint xs [0:MAX_FEATURES], input int fc, input int k);
		longint acc;
		acc = 0;
		for (int f = 0; f < fc; f++) acc += xs[f] * longint'(weights[f*MAX_TARGETS+k]);
		acc += longint'(BIAS_Q8) * longint'(weights[fc*MAX_TARGETS+k]);
		return acc >= 0;
	endfunction

	function automatic logic epoch_has_errors(input int fc, input int tc, input int rc);
		longint xs [0:MAX_FEATURES];
		longint d;
		longint inc;
		longint sum;
		logic    errors;
		int      base;
		errors = 1'b0;
		foreach (deltas[i]) deltas[i] = 0;
		for (int r = 0; r < rc; r++) begin
			base = r * ROW_STRIDE;
			for (int f = 0; f < fc; f++) xs[f] = longint'($signed(samples[base+f]));
			xs[fc] = BIAS_Q8;
			for (int k = 0; k < tc; k++) begin
				d = longint'($signed(samples[base+fc+k])) - longint'(fire(xs, fc, k));
				if (d != 0) errors = 1'b1;
				for (int f = 0; f <= fc; f++) deltas[f*MAX_TARGETS+k] += xs[f] * d;
			end
		end
		if (errors) begin
			for (int f = 0; f <= fc; f++)
				for (int k = 0; k < tc; k++) begin
					inc = (deltas[f*MAX_TARGETS+k] * 6554 + 128) >>> 8;
					sum = longint'(weights[f*MAX_TARGETS+k]) + inc;
					if (sum > 64'sd2147483647) sum = 64'sd2147483647;
					if (sum < -64'sd2147483648) sum = -64'sd2147483648;
					weights[f*MAX_TARGETS+k] = int'(sum);
				end
		end
		return errors;
	endfunction

	function automatic void train_and_report();
		int          fc;
		int          tc;
		int          rc;
		logic        conv;
		logic [15:0] epochs;
		longint      r16;
		result_t     rep;
		fc = clampi(cfg_features, 1, MAX_FEATURES);
		tc = clampi(cfg_targets, 1, MAX_TARGETS);
		rc = clampi(cfg_rows, 1, MAX_ROWS);
		lfsr = (cfg_seed != 0) ? cfg_seed : 32'd1;
		for (int f = 0; f <= fc; f++)
			for (int k = 0; k < tc; k++) begin
				repeat (16) lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
				r16 = longint'($signed(lfsr[15:0]));
				weights[f*MAX_TARGETS+k] = int'((r16 * 6554) >>> 15);
			end
		epochs = '0;
		forever begin
			if (!epoch_has_errors(fc, tc, rc)) begin
				conv = 1'b1;
				break;
			end
			if (epochs < cfg_cap) epochs++;
			else begin
				conv = 1'b0;
				break;
			end
		end
		rep = '{KIND_REPORT, epochs, conv, 3'd0, 1'b0, 1'b1};
		result_q.push_back(rep);
	endfunction

	function automatic void predict_test_row();
		longint  xs [0:MAX_FEATURES];
		int      fc;
		int      tc;
		result_t p;
		fc = clampi(cfg_features, 1, MAX_FEATURES);
		tc = clampi(cfg_targets, 1, MAX_TARGETS);
		for (int f = 0; f < fc; f++) xs[f] = longint'($signed(test_vec[f]));
		for (int k = 0; k < tc; k++) begin
			p = '{KIND_PREDICT, 16'd0, 1'b0, 3'(k), fire(xs, fc, k), k + 1 == tc};
			result_q.push_back(p);
		end
	endfunction

	function automatic void compare(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		logic [7:0]  row;
		logic [4:0]  col;
		logic [15:0] val;
		result_t     want;
		if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_FEATURES: cfg_features = pwdata[4:0];
				REG_TARGETS:  cfg_targets  = pwdata[3:0];
				REG_ROWS:     cfg_rows     = pwdata[8:0];
				REG_EPOCHCAP: cfg_cap      = pwdata[15:0];
				REG_SEED:     cfg_seed     = pwdata;
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			row = s_tdata[7:0];
			col = s_tdata[12:8];
			val = s_tdata[28:13];
			case (s_tuser)
				FUNC_LOAD: if (col < ROW_STRIDE) samples[row*ROW_STRIDE+col] = val;
				FUNC_TRAIN: train_and_report();
				FUNC_TEST: begin
					if (col < MAX_FEATURES) test_vec[col] = val;
					if (s_tlast) predict_test_row();
				end
				default: ;
			endcase
		end
		if (m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$error("result beat with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
				fails++;
			end else begin
				want = result_q.pop_front();
				compare("result_kind", want.kind, m_tuser);
				compare("epochs_used", want.epochs, m_tdata[15:0]);
				compare("converged", want.conv, m_tdata[16]);
				compare("target_number", want.tnum, m_tdata[19:17]);
				compare("prediction", want.pred, m_tdata[20]);
				compare("last_result", want.last, m_tlast);
			end
		end
		pending <= result_q.size();
	end

endmodule

@@ sim/tb_batch_perceptron_trainer.sv @@
// Testbench top: drives config, training data, training starts and test rows; gives the verdict.
`timescale 1ns / 1ps
module tb_batch_perceptron_trainer;
	import bpt_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fails;
	int          pending;

	int burst_left = 0;
	int ready_hold = 0;
	int beats_sent = 0;
	int fc = 2;
	int tc = 1;
	int rc = 4;

	always #6 clk = ~clk;

	batch_perceptron_trainer uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	bpt_checker u_checker (
		.clk(clk),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready), .fails(fails), .pending(pending)
	);

	always @(posedge clk) begin
		if (ready_hold == 0) begin
			m_tready <= ~m_tready;
			ready_hold <= m_tready ? $urandom_range(0, 6) : $urandom_range(0, 40);
		end else begin
			ready_hold <= ready_hold - 1;
		end
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send(input logic [1:0] func, input logic [7:0] row, input logic [4:0] col,
			input logic [15:0] val, input logic last, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {3'b000, val, col, row};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (counted) beats_sent++;
	endtask

	// drain every expected result, then let the block settle
	task automatic go_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic configure(input logic [4:0] f, input logic [3:0] t, input logic [8:0] r,
			input logic [15:0] cap, input logic [31:0] seed);
		go_idle();
		reg_write(REG_FEATURES, f);
		reg_write(REG_TARGETS, t);
		reg_write(REG_ROWS, r);
		reg_write(REG_EPOCHCAP, cap);
		reg_write(REG_SEED, seed);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		fc = f < 1 ? 1 : (f > MAX_FEATURES ? MAX_FEATURES : f);
		tc = t < 1 ? 1 : (t > MAX_TARGETS ? MAX_TARGETS : t);
		rc = r < 1 ? 1 : (r > MAX_ROWS ? MAX_ROWS : r);
	endtask

	function automatic logic [15:0] feature_val();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 1023) - 512);
		endcase
	endfunction

	function automatic logic [15:0] target_val();
		return ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
	endfunction

	task automatic noise();
		case ($urandom_range(0, 2))
			0: send(FUNC_LOAD, 8'($urandom), 5'($urandom_range(ROW_STRIDE, 31)),
				16'($urandom), 1'($urandom), 1'b0);
			1: send(2'd3, 8'($urandom), 5'($urandom), 16'($urandom), 1'($urandom), 1'b0);
			default: send(FUNC_TEST, 8'($urandom), 5'($urandom_range(MAX_FEATURES, 31)),
				16'($urandom), 1'b0, 1'b0);
		endcase
	endtask

	task automatic load_rows();
		for (int r = 0; r < rc; r++)
			for (int c = 0; c < fc + tc; c++) begin
				if ($urandom_range(0, 19) == 0) noise();
				send(FUNC_LOAD, 8'(r), 5'(c), c < fc ? feature_val() : target_val(),
					1'($urandom), 1'b1);
			end
	endtask

	task automatic test_rows(input int n);
		for (int i = 0; i < n; i++)
			for (int c = 0; c < fc; c++) begin
				if ($urandom_range(0, 9) == 0) noise();
				send(FUNC_TEST, 8'($urandom), 5'(c), feature_val(), c == fc - 1, 1'b1);
			end
	endtask

	task automatic train();
		send(FUNC_TRAIN, 8'($urandom), 5'($urandom), 16'($urandom), 1'($urandom), 1'b1);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// untrained weights, extreme features, unknown func, out-of-range columns
		send(FUNC_TEST, 8'd0, 5'd0, 16'h8000, 1'b0, 1'b1);
		send(FUNC_TEST, 8'd255, 5'd1, 16'h7fff, 1'b1, 1'b1);
		send(2'd3, 8'hff, 5'd31, 16'hffff, 1'b1, 1'b0);
		send(FUNC_TEST, 8'd7, 5'd31, 16'h1234, 1'b1, 1'b1);
		send(FUNC_LOAD, 8'd3, 5'd24, 16'hffff, 1'b0, 1'b0);

		configure(5'd2, 4'd1, 9'd4, 16'd20, $urandom);
		load_rows();
		train();
		test_rows(3);

		configure(5'd31, 4'd15, 9'd3, 16'd5, 32'hffff_ffff);
		load_rows();
		train();
		test_rows(2);

		configure(5'd0, 4'd0, 9'd40, 16'd2, 32'd0);
		load_rows();
		train();
		test_rows(3);

		// single row that the rule learns fast, so the top epoch cap never binds
		configure(5'd1, 4'd1, 9'd0, 16'd65535, 32'd1);
		send(FUNC_LOAD, 8'd0, 5'd0, 16'd256, 1'b0, 1'b1);
		send(FUNC_LOAD, 8'd0, 5'd1, 16'd1, 1'b0, 1'b1);
		train();
		test_rows(2);

		for (int p = 0; p < 3 || beats_sent < 360; p++) begin
			configure(5'($urandom_range(1, 4)), 4'($urandom_range(1, 3)),
				9'($urandom_range(1, 8)), 16'($urandom_range(1, 30)), $urandom);
			load_rows();
			train();
			test_rows($urandom_range(1, 4));
			if ($urandom_range(0, 1)) begin
				train();
				test_rows(1);
			end
		end

		go_idle();
		repeat (200) @(posedge clk);
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bpt_pkg.sv
hdl/batch_perceptron_trainer.sv
sim/bpt_checker.sv
sim/tb_batch_perceptron_trainer.sv
